// ===== sv/adnp_pkg.sv =====
// ----------------------------------------------------------------------------
// adnp_pkg
// Shared types and constants for the ASCII decimal number parser.
// ----------------------------------------------------------------------------
package adnp_pkg;

	localparam int unsigned MAX_FRAC_DIGITS_DEF = 18;
	localparam int unsigned FRAC_W = 5;
	localparam int unsigned MAG_W = 64;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [MAG_W-1:0] MAG_LIMIT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [MAG_W-1:0] MAG_LIMIT_NEG = 64'h8000_0000_0000_0000;
	// floor(limit / 10); one less when the incoming digit passes the limit's last digit
	localparam logic [MAG_W-1:0] SAT_THRESH    = 64'd922337203685477580;

	typedef struct packed {
		logic              begun;
		logic              seen;
		logic              negative;
		logic              in_fraction;
		logic              finished;
		logic [MAG_W-1:0]  magnitude;
		logic [FRAC_W-1:0] frac_count;
		logic              saturated;
	} parse_state_t;

	typedef struct packed {
		logic              is_number;
		logic              is_fraction;
		logic [MAG_W-1:0]  value;
		logic [FRAC_W-1:0] frac_digits;
		logic              overflow;
	} result_t;

endpackage

// ===== sv/adnp_core.sv =====
// ----------------------------------------------------------------------------
// adnp_core
// Input register and per-character parse step; emits one result word at
// each terminator.
// ----------------------------------------------------------------------------
module adnp_core #(
	parameter int unsigned MAX_FRAC_DIGITS = adnp_pkg::MAX_FRAC_DIGITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          ch,
	input  logic                res_free,
	output logic                res_load,
	output adnp_pkg::result_t   res
);

	localparam logic [adnp_pkg::FRAC_W-1:0] MaxFrac = adnp_pkg::FRAC_W'(MAX_FRAC_DIGITS);

	logic                   valid_s1;
	logic [7:0]             ch_s1;
	adnp_pkg::parse_state_t st_q;
	adnp_pkg::parse_state_t st_d;
	logic                   is_term;
	logic                   advance;
	logic [3:0]             digit;
	logic [adnp_pkg::MAG_W-1:0] thresh;
	logic [adnp_pkg::MAG_W-1:0] limit;
	logic [adnp_pkg::MAG_W-1:0] mag10;

	assign is_term  = (ch_s1 == adnp_pkg::CH_NUL);
	assign advance  = valid_s1 && (!is_term || res_free);
	assign in_stall = valid_s1 && !advance;
	assign res_load = advance && is_term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			ch_s1 <= ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_d;
		end
	end

	assign digit  = 4'(ch_s1 - adnp_pkg::CH_ZERO);
	assign limit  = st_q.negative ? adnp_pkg::MAG_LIMIT_NEG : adnp_pkg::MAG_LIMIT_POS;
	assign thresh = adnp_pkg::SAT_THRESH
		- adnp_pkg::MAG_W'(digit > (st_q.negative ? 4'd8 : 4'd7));
	assign mag10  = {st_q.magnitude[adnp_pkg::MAG_W-4:0], 3'b000}
		+ {st_q.magnitude[adnp_pkg::MAG_W-2:0], 1'b0}
		+ adnp_pkg::MAG_W'(digit);

	always_comb begin
		st_d = st_q;
		if (is_term) begin
			st_d = '0;
		end else if (!st_q.finished) begin
			if (ch_s1 == adnp_pkg::CH_PLUS || ch_s1 == adnp_pkg::CH_MINUS) begin
				if (st_q.begun) begin
					st_d.finished = 1'b1;
				end else begin
					st_d.begun    = 1'b1;
					st_d.negative = (ch_s1 == adnp_pkg::CH_MINUS);
				end
			end else if (ch_s1 == adnp_pkg::CH_POINT) begin
				if (st_q.in_fraction) begin
					st_d.finished = 1'b1;
				end else begin
					st_d.in_fraction = 1'b1;
					st_d.begun       = 1'b1;
					st_d.seen        = 1'b1;
				end
			end else if (ch_s1 inside {[adnp_pkg::CH_ZERO:adnp_pkg::CH_NINE]}) begin
				st_d.begun = 1'b1;
				st_d.seen  = 1'b1;
				if (!st_q.saturated && !(st_q.in_fraction && st_q.frac_count >= MaxFrac)) begin
					if (st_q.magnitude > thresh) begin
						st_d.magnitude = limit;
						st_d.saturated = 1'b1;
					end else begin
						st_d.magnitude = mag10;
						if (st_q.in_fraction) begin
							st_d.frac_count = st_q.frac_count + 1'b1;
						end
					end
				end
			end else if (st_q.begun) begin
				st_d.finished = 1'b1;
			end
		end
	end

	// drop everything to zero when no digit or point was seen
	always_comb begin
		res = '0;
		if (st_q.seen) begin
			res.is_number   = 1'b1;
			res.is_fraction = st_q.in_fraction;
			res.value       = st_q.negative ? (~st_q.magnitude + 1'b1) : st_q.magnitude;
			res.frac_digits = st_q.in_fraction ? st_q.frac_count : '0;
			res.overflow    = st_q.saturated;
		end
	end

`ifndef SYNTH
	a_finished_begun: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.finished |-> st_q.begun) else $error("finished without begun");
	a_frac_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.frac_count <= MaxFrac) else $error("fraction count past limit");
	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> (st_q == '0)) else $error("state not cleared after terminator");
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.saturated |-> (st_q.magnitude == limit)) else $error("saturated off limit");
`endif

endmodule

// ===== sv/adnp_out_reg.sv =====
// ----------------------------------------------------------------------------
// adnp_out_reg
// Result register; holds a word until the output side takes it.
// ----------------------------------------------------------------------------
module adnp_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_load,
	input  adnp_pkg::result_t res,
	output logic              res_free,
	output logic              out_valid,
	input  logic              out_stall,
	output adnp_pkg::result_t out_q
);

	logic out_valid_q;

	assign res_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q <= res;
		end
	end

`ifndef SYNTH
	a_no_number_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.is_number |-> (out_q.value == '0) && !out_q.overflow
		&& !out_q.is_fraction) else $error("empty result not zero");
	a_int_no_frac: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.is_fraction |-> (out_q.frac_digits == '0))
		else $error("fraction digits on integer");
	a_ovf_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.overflow |-> (out_q.value == adnp_pkg::MAG_LIMIT_POS
		|| out_q.value == adnp_pkg::MAG_LIMIT_NEG)) else $error("overflow value off limit");
`endif

endmodule

// ===== sv/ascii_decimal_number_parser.sv =====
// ----------------------------------------------------------------------------
// ascii_decimal_number_parser
// Parses a zero-terminated ASCII decimal string, one character per word,
// into a signed mantissa, fraction digit count and status flags.
// ----------------------------------------------------------------------------
//   channel  handshake            payload
//   in       in_valid / in_stall  ch
//   out      out_valid / out_stall is_number, is_fraction, value,
//                                 frac_digits, overflow
//
// One character per cycle while no terminator waits on a stalled output; a
// terminator enters the input register, and its result then the result register.
// The per-character step (multiply by ten, add, limit compare) sits between
// the input register and the parse state registers.
// Reset (arst_n low) clears parse state and both valid flags at once.
// A stalled output holds back a terminator and the input behind it; other characters keep flowing.
// ----------------------------------------------------------------------------
module ascii_decimal_number_parser #(
	parameter int unsigned MAX_FRAC_DIGITS = adnp_pkg::MAX_FRAC_DIGITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          ch,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                is_number,
	output logic                is_fraction,
	output logic signed [63:0]  value,
	output logic [4:0]          frac_digits,
	output logic                overflow
);

	adnp_pkg::result_t res;
	adnp_pkg::result_t out_q;
	logic              res_load;
	logic              res_free;

	adnp_core #(
		.MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.ch       (ch),
		.res_free (res_free),
		.res_load (res_load),
		.res      (res)
	);

	adnp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_load  (res_load),
		.res       (res),
		.res_free  (res_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_q     (out_q)
	);

	assign is_number   = out_q.is_number;
	assign is_fraction = out_q.is_fraction;
	assign value       = signed'(out_q.value);
	assign frac_digits = out_q.frac_digits;
	assign overflow    = out_q.overflow;

endmodule

// ===== tb/sv/ascii_decimal_number_parser_tb.sv =====
// ----------------------------------------------------------------------------
// ascii_decimal_number_parser_tb
// Feeds zero-terminated strings one byte per word into the parser: a directed
// set of edge cases first, then random strings, most of them shaped like
// numbers. A predictor follows every accepted byte and keeps the expected
// numbers in order. Each result word is checked field by field against them.
// Both sides idle at random, the receiver holds off once for a long stretch,
// and the sender pauses for a full drain from time to time.
// ----------------------------------------------------------------------------
module ascii_decimal_number_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAUSE_MARK     = -1;
	localparam int TEXT_TARGET    = 2000;
	localparam int IDLE_PCT       = 33;
	localparam int SEND_CALM_LO   = 600;
	localparam int SEND_CALM_HI   = 1000;
	localparam int RECV_CALM_LO   = 60;
	localparam int RECV_CALM_HI   = 110;
	localparam int HOLD_AT        = 30;
	localparam int HOLD_LEN       = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 16;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         ch = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               is_number;
	logic               is_fraction;
	logic signed [63:0] value;
	logic [4:0]         frac_digits;
	logic               overflow;

	int                     text_bytes[$];
	adnp_pkg::result_t      parsed_numbers[$];
	adnp_pkg::parse_state_t number_state = '0;
	adnp_pkg::result_t      want;
	int                     bytes_sent = 0;
	int                     numbers_seen = 0;
	int                     hold_left = 0;
	bit                     hold_done = 1'b0;
	int                     quiet_cycles = 0;
	int                     fail_count = 0;

	ascii_decimal_number_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.ch(ch),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.is_number(is_number),
		.is_fraction(is_fraction),
		.value(value),
		.frac_digits(frac_digits),
		.overflow(overflow)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Follow one accepted byte; a terminator yields the expected number.
	task automatic advance_number(input logic [7:0] c);
		logic [63:0]       digit;
		logic [63:0]       limit;
		adnp_pkg::result_t num;
		if (c == adnp_pkg::CH_NUL) begin
			num = '0;
			if (number_state.seen) begin
				num.is_number   = 1'b1;
				num.is_fraction = number_state.in_fraction;
				num.value       = number_state.negative ? -number_state.magnitude
					: number_state.magnitude;
				num.frac_digits = number_state.in_fraction ? number_state.frac_count : '0;
				num.overflow    = number_state.saturated;
			end
			parsed_numbers.push_back(num);
			number_state = '0;
		end else if (!number_state.finished) begin
			if (c == adnp_pkg::CH_PLUS || c == adnp_pkg::CH_MINUS) begin
				if (number_state.begun) begin
					number_state.finished = 1'b1;
				end else begin
					number_state.begun = 1'b1;
					if (c == adnp_pkg::CH_MINUS)
						number_state.negative = 1'b1;
				end
			end else if (c == adnp_pkg::CH_POINT) begin
				if (number_state.in_fraction) begin
					number_state.finished = 1'b1;
				end else begin
					number_state.in_fraction = 1'b1;
					number_state.begun = 1'b1;
					number_state.seen = 1'b1;
				end
			end else if (c >= adnp_pkg::CH_ZERO && c <= adnp_pkg::CH_NINE) begin
				digit = 64'(c - adnp_pkg::CH_ZERO);
				number_state.begun = 1'b1;
				number_state.seen = 1'b1;
				if (!number_state.saturated && !(number_state.in_fraction &&
						number_state.frac_count >= adnp_pkg::MAX_FRAC_DIGITS_DEF)) begin
					limit = number_state.negative ? adnp_pkg::MAG_LIMIT_NEG
						: adnp_pkg::MAG_LIMIT_POS;
					if (number_state.magnitude > (limit - digit) / 64'd10) begin
						number_state.magnitude = limit;
						number_state.saturated = 1'b1;
					end else begin
						number_state.magnitude = number_state.magnitude * 64'd10 + digit;
						if (number_state.in_fraction)
							number_state.frac_count = number_state.frac_count + 5'd1;
					end
				end
			end else if (number_state.begun) begin
				number_state.finished = 1'b1;
			end
		end
	endtask

	// Sender: predict on acceptance, hold while stalled, idle at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			ch <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				advance_number(ch);
				bytes_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (text_bytes.size() != 0 && text_bytes[0] == PAUSE_MARK) begin
					if (parsed_numbers.size() == 0)
						void'(text_bytes.pop_front());
					in_valid <= 1'b0;
				end else if (text_bytes.size() != 0 &&
						((bytes_sent >= SEND_CALM_LO && bytes_sent < SEND_CALM_HI) ||
						$urandom_range(99) >= IDLE_PCT)) begin
					ch <= 8'(text_bytes.pop_front());
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each accepted word against the oldest expected number.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (parsed_numbers.size() == 0) begin
					$error("result word with no number expected");
					fail_count++;
				end else begin
					want = parsed_numbers.pop_front();
					if (is_number !== want.is_number) begin
						$error("is_number: expected %0d, got %0d", want.is_number, is_number);
						fail_count++;
					end
					if (is_fraction !== want.is_fraction) begin
						$error("is_fraction: expected %0d, got %0d", want.is_fraction,
							is_fraction);
						fail_count++;
					end
					if (value !== want.value) begin
						$error("value: expected %0d, got %0d", $signed(want.value), value);
						fail_count++;
					end
					if (frac_digits !== want.frac_digits) begin
						$error("frac_digits: expected %0d, got %0d", want.frac_digits,
							frac_digits);
						fail_count++;
					end
					if (overflow !== want.overflow) begin
						$error("overflow: expected %0d, got %0d", want.overflow, overflow);
						fail_count++;
					end
				end
				numbers_seen++;
			end
			// Hold off once for long enough that the parser backs up to its input.
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!hold_done && numbers_seen >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN - 1;
				out_stall <= 1'b1;
			end else if (numbers_seen >= RECV_CALM_LO && numbers_seen < RECV_CALM_HI) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int pick_digit();
		return int'(adnp_pkg::CH_ZERO) + $urandom_range(9);
	endfunction

	// Any byte that cannot start a number.
	function automatic int pick_lead_junk();
		int c;
		do
			c = $urandom_range(1, 255);
		while (c == adnp_pkg::CH_PLUS || c == adnp_pkg::CH_MINUS ||
			c == adnp_pkg::CH_POINT ||
			(c >= adnp_pkg::CH_ZERO && c <= adnp_pkg::CH_NINE));
		return c;
	endfunction

	// Any non-zero byte, weighted towards the characters the parser cares about.
	function automatic int pick_noise();
		string marks;
		marks = "+-.0123456789";
		if ($urandom_range(1))
			return $urandom_range(1, 255);
		return int'(marks[$urandom_range(marks.len() - 1)]);
	endfunction

	function automatic int pick_len();
		if ($urandom_range(9) == 0)
			return $urandom_range(15, 22);
		return $urandom_range(0, 6);
	endfunction

	task automatic add_text(input string s);
		foreach (s[i])
			text_bytes.push_back(int'(s[i]));
		text_bytes.push_back(int'(adnp_pkg::CH_NUL));
	endtask

	task automatic add_random_text();
		string near;
		int    kind;
		int    point_at;
		near = "92233720368547758";
		kind = $urandom_range(99);
		if (kind < 10) begin
			repeat ($urandom_range(0, 12))
				text_bytes.push_back(pick_noise());
		end else begin
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(1, 3))
					text_bytes.push_back(pick_lead_junk());
			case ($urandom_range(2))
				1: text_bytes.push_back(int'(adnp_pkg::CH_PLUS));
				2: text_bytes.push_back(int'(adnp_pkg::CH_MINUS));
				default: ;
			endcase
			if (kind < 25) begin
				// digits around the saturation limit, sometimes with a point inside
				point_at = $urandom_range(0, 30);
				foreach (near[i]) begin
					if (point_at == i)
						text_bytes.push_back(int'(adnp_pkg::CH_POINT));
					text_bytes.push_back(int'(near[i]));
				end
				repeat ($urandom_range(1, 3))
					text_bytes.push_back(pick_digit());
			end else begin
				repeat (pick_len())
					text_bytes.push_back(pick_digit());
				if ($urandom_range(1)) begin
					text_bytes.push_back(int'(adnp_pkg::CH_POINT));
					repeat (pick_len())
						text_bytes.push_back(pick_digit());
				end
			end
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(1, 4))
					text_bytes.push_back(pick_noise());
		end
		text_bytes.push_back(int'(adnp_pkg::CH_NUL));
	endtask

	initial begin
		string directed[$];
		directed = '{"", "-", "x+", ".", "-0", "ab-7.25xyz", "1..2", "3-4", "7 8",
			"9223372036854775807", "-9223372036854775808", "9223372036854775808",
			"-9223372036854775809", ".0123456789012345678912",
			"922337203685477580.78", "12\3774"};
		foreach (directed[i])
			add_text(directed[i]);
		text_bytes.push_back(PAUSE_MARK);
		while (text_bytes.size() < TEXT_TARGET) begin
			add_random_text();
			if (text_bytes.size() % 700 < 12)
				text_bytes.push_back(PAUSE_MARK);
		end
		text_bytes.push_back(PAUSE_MARK);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (text_bytes.size() != 0 || in_valid || parsed_numbers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
